// ===== hdl/sif_pkg.sv =====
// shared constants for the shift-insert free-slot unit
// no dependencies; used by the top level and the ram wrapper sizing

package sif_pkg;

   localparam int CAPACITY   = 1024;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = 10;
   localparam int RDV_W      = 32;
   localparam int ULEN_W     = 11;

endpackage

// ===== hdl/sif_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies

module sif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/shift_insert_to_free_slot_unit.sv =====
// shift-insert row with first-free-slot absorption, top level
// depends on sif_pkg and sif_ram

// A row of cells in one ram, zero meaning free. An insert writes its value at
// the position and pushes the occupied run above it one cell up, into the first
// free cell (or off the end, flagging overflow). A read returns one cell. Every
// request gives exactly one response on rsp_strobe for one cycle; the receiver
// cannot stall it. After reset a clearing pass zeroes the ram while busy is
// high. An insert walks the ram one cell per cycle, read and write-back
// overlapped, from the position up to the first free cell. An overflowing
// insert of zero at the last cell adds a downward scan of the ram, one cell
// per cycle, to find the new used length.

module shift_insert_to_free_slot_unit
   import sif_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [POS_W-1:0]      req_position,
   input  logic [31:0]           req_value,
   output logic                  rsp_strobe,
   output logic [RDV_W-1:0]      rsp_read_value,
   output logic [ULEN_W-1:0]     rsp_used_length,
   output logic                  rsp_overflow
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_SHIFT, ST_RESCAN
   } state_type;

   state_type              state_ff;
   logic [ADDR_W-1:0]      cur_ff;      // cell whose read data arrives now
   logic [VALUE_BITS-1:0]  carry_ff;    // value to be written into cur_ff
   logic [LEN_W-1:0]       len_ff;
   logic                   rd_ok_ff;
   logic                   rsp_strobe_ff;
   logic [RDV_W-1:0]       rsp_read_value_ff;
   logic [LEN_W-1:0]       rsp_len_ff;
   logic                   rsp_overflow_ff;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [VALUE_BITS-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [VALUE_BITS-1:0]  ram_rd_data;

   logic                   accept;
   logic                   pos_ok;
   logic                   at_last;
   logic [LEN_W-1:0]       cur_plus1;
   logic [LEN_W-1:0]       grown_len;

   assign accept    = start && !busy;
   assign pos_ok    = int'(req_position) < CAPACITY;
   assign at_last   = int'(cur_ff) == CAPACITY - 1;
   assign cur_plus1 = LEN_W'(cur_ff) + LEN_W'(1);
   assign grown_len = (cur_plus1 > len_ff) ? cur_plus1 : len_ff;

   // ram port steering
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_ff;
      ram_wr_data = carry_ff;
      ram_rd_addr = cur_ff + ADDR_W'(1);
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            ram_rd_addr = ADDR_W'(req_position);
         end
         ST_SHIFT: begin
            ram_wr_en = 1'b1;     // write carry into this cell, read the next
         end
         ST_RESCAN: begin
            ram_rd_addr = cur_ff - ADDR_W'(1);
         end
         default: begin
         end
      endcase
   end

   sif_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cur_ff        <= '0;
         len_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               rsp_strobe_ff <= 1'b0;
               if (at_last) begin
                  cur_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  cur_ff <= cur_ff + ADDR_W'(1);
               end
            end
            ST_IDLE: begin
               // insert out of range answers at once and changes nothing
               rsp_strobe_ff <= accept && !req_op && !pos_ok;
               if (accept) begin
                  cur_ff   <= ADDR_W'(req_position);
                  carry_ff <= VALUE_BITS'(req_value);
                  rd_ok_ff <= pos_ok;
                  if (req_op) begin
                     state_ff <= ST_READ;
                  end else if (pos_ok) begin
                     state_ff <= ST_SHIFT;
                  end else begin
                     rsp_read_value_ff <= '0;
                     rsp_len_ff        <= len_ff;
                     rsp_overflow_ff   <= 1'b0;
                  end
               end
            end
            ST_READ: begin
               rsp_strobe_ff     <= 1'b1;
               rsp_read_value_ff <= rd_ok_ff ? RDV_W'(ram_rd_data) : '0;
               rsp_len_ff        <= len_ff;
               rsp_overflow_ff   <= 1'b0;
               state_ff          <= ST_IDLE;
            end
            ST_SHIFT: begin
               carry_ff <= ram_rd_data;
               if (ram_rd_data == '0 || at_last) begin
                  rsp_read_value_ff <= '0;
                  rsp_overflow_ff   <= (ram_rd_data != '0);
                  if (carry_ff != '0) begin
                     len_ff        <= grown_len;
                     rsp_len_ff    <= grown_len;
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end else if (ram_rd_data != '0 && cur_plus1 == len_ff) begin
                     // zero written over the top occupied cell: scan down
                     rsp_strobe_ff <= 1'b0;
                     state_ff      <= ST_RESCAN;
                  end else begin
                     rsp_len_ff    <= len_ff;
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end
               end else begin
                  cur_ff        <= cur_ff + ADDR_W'(1);
                  rsp_strobe_ff <= 1'b0;
               end
            end
            ST_RESCAN: begin
               // read data belongs to cur_ff once the first read is back
               cur_ff <= cur_ff - ADDR_W'(1);
               if (cur_ff != ADDR_W'(CAPACITY - 1) && ram_rd_data != '0) begin
                  len_ff        <= LEN_W'(cur_ff) + LEN_W'(1);
                  rsp_len_ff    <= LEN_W'(cur_ff) + LEN_W'(1);
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else if (cur_ff == '0) begin
                  len_ff        <= '0;
                  rsp_len_ff    <= '0;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  rsp_strobe_ff <= 1'b0;
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_used_length = ULEN_W'(rsp_len_ff);
   assign rsp_overflow    = rsp_overflow_ff;

endmodule

// ===== tb/shift_insert_to_free_slot_unit_test.sv =====
// self-checking bench for the shift-insert free-slot unit
// depends on sif_pkg and the shift_insert_to_free_slot_unit rtl

module shift_insert_to_free_slot_unit_test;
   import sif_pkg::*;

   typedef enum logic {OP_INSERT = 1'b0, OP_READ = 1'b1} row_op_type;

   typedef struct packed {
      logic [RDV_W-1:0]  read_value;
      logic [ULEN_W-1:0] used_length;
      logic              overflow;
   } row_rsp_type;

   localparam int STALL_LIMIT = 20000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_op;
   logic [POS_W-1:0]  req_position;
   logic [31:0]       req_value;
   logic              rsp_strobe;
   logic [RDV_W-1:0]  rsp_read_value;
   logic [ULEN_W-1:0] rsp_used_length;
   logic              rsp_overflow;

   // private copy of the row, used to work out each response
   logic [VALUE_BITS-1:0] row_cells [CAPACITY];
   row_rsp_type           pending_rsp [$];
   int                    mismatch_count = 0;
   int                    idle_pct;
   int                    quiet_cycles;

   shift_insert_to_free_slot_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_position(req_position), .req_value(req_value),
      .rsp_strobe(rsp_strobe), .rsp_read_value(rsp_read_value),
      .rsp_used_length(rsp_used_length), .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // apply one request to the row copy and return the response it gives
   function automatic row_rsp_type row_apply(row_op_type op, logic [POS_W-1:0] pos,
                                             logic [31:0] val);
      row_rsp_type r;
      int          free_at;
      int          n;
      r = '0;
      if (op == OP_READ) begin
         if (pos < CAPACITY) r.read_value = RDV_W'(row_cells[pos]);
      end else if (pos < CAPACITY) begin
         free_at = pos;
         while (free_at < CAPACITY && row_cells[free_at] != '0) free_at++;
         if (free_at >= CAPACITY) begin
            free_at = CAPACITY - 1;
            r.overflow = 1'b1;
         end
         for (int i = free_at; i > pos; i--) row_cells[i] = row_cells[i-1];
         row_cells[pos] = VALUE_BITS'(val);
      end
      // used length: one past the highest nonzero cell
      n = CAPACITY;
      while (n > 0 && row_cells[n-1] == '0) n--;
      r.used_length = ULEN_W'(n);
      return r;
   endfunction

   // send one request, holding start until the block takes it
   task automatic send_request(row_op_type op, int pos, logic [31:0] val);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
         while (($urandom_range(99) < idle_pct)) @(negedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_position <= POS_W'(pos);
      req_value    <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp = {pending_rsp, row_apply(op, POS_W'(pos), val)};
      @(negedge clock);
   endtask

   // response checker: every strobe is matched against the oldest expectation
   always @(posedge clock) begin
      row_rsp_type got;
      row_rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         got = '{rsp_read_value, rsp_used_length, rsp_overflow};
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response rd=%h len=%0d ovf=%b",
                        got.read_value, got.used_length, got.overflow);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (got !== exp_rsp) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp rd=%h len=%0d ovf=%b, got rd=%h len=%0d ovf=%b",
                           exp_rsp.read_value, exp_rsp.used_length, exp_rsp.overflow,
                           got.read_value, got.used_length, got.overflow);
            end
         end
      end
   end

   // watchdog: counts cycles where neither a request nor a response moves
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // edges and special cases on a fresh row
   task automatic test_directed();
      send_request(OP_READ, 0, 32'h0);
      send_request(OP_INSERT, 0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 0, 32'h0000_0001);     // shifts run up
      send_request(OP_INSERT, 1, 32'h0);             // zero leaves a free cell
      send_request(OP_INSERT, 1023, 32'hA5A5_5A5A);  // last cell
      send_request(OP_READ, 1023, 32'h0);
      send_request(OP_INSERT, 1022, 32'h1234_5678);
      send_request(OP_INSERT, 1023, 32'h0);          // overwrite last with zero
      send_request(OP_READ, 0, 32'h0);
      send_request(OP_READ, 1, 32'hFFFF_FFFF);
      send_request(OP_READ, 2, 32'h0);
      send_request(OP_INSERT, 512, 32'h8000_0000);
      send_request(OP_READ, 512, 32'h0);
   endtask

   // mixed random traffic with a clustered position range
   task automatic test_random(int count, int idle);
      int pos;
      idle_pct = idle;
      repeat (count) begin
         pos = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(40);
         send_request(row_op_type'($urandom_range(2) == 0),
                      pos, ($urandom_range(9) == 0) ? 32'h0 : $urandom());
      end
   endtask

   // fill the whole row, then force overflows including a dropped tail
   task automatic test_overflow();
      idle_pct = 0;
      for (int i = 0; i < CAPACITY; i++) send_request(OP_INSERT, i, $urandom() | 32'h1);
      repeat (6) send_request(OP_INSERT, $urandom_range(1023), $urandom() | 32'h1);
      send_request(OP_INSERT, 1023, 32'h0);          // overflow with zero at the end
      send_request(OP_INSERT, 1000, 32'h0);
      send_request(OP_READ, 1023, 32'h0);
   endtask

   initial begin
      idle_pct       = 32;
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = 1'b0;
      req_position   = '0;
      req_value      = '0;
      foreach (row_cells[i]) row_cells[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(300, 32);
      test_random(200, 0);
      test_overflow();
      test_random(100, 32);
      start <= 1'b0;

      // drain, then give the tail scan time to settle
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * CAPACITY + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sif_pkg.sv
hdl/sif_ram.sv
hdl/shift_insert_to_free_slot_unit.sv
tb/shift_insert_to_free_slot_unit_test.sv
